[rtl/core/ire_pkg.sv]
// shared constants, types and codes of the image resize core
package ire_pkg;

  // store geometry and fixed-point format
  localparam int MAX_IN_HEIGHT = 256;
  localparam int MAX_IN_WIDTH  = 256;
  localparam int FRAC_BITS     = 16;

  localparam int MAX_IN_DIM = (MAX_IN_HEIGHT > MAX_IN_WIDTH) ? MAX_IN_HEIGHT : MAX_IN_WIDTH;
  localparam int IDX_W      = (MAX_IN_DIM > 1) ? $clog2(MAX_IN_DIM) : 1;
  localparam int CNT_W      = $clog2(MAX_IN_DIM + 1);
  localparam int ROW_W      = $clog2(MAX_IN_HEIGHT);
  localparam int COL_W      = $clog2(MAX_IN_WIDTH);

  // port field widths
  localparam int IN_SIZE_W   = 9;
  localparam int OUT_SIZE_W  = 13;
  localparam int COORD_W     = 12;
  localparam int SAMPLE_W    = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  // scale and coordinate arithmetic
  localparam int SCALE_W   = CNT_W + FRAC_BITS;
  localparam int MUL_W     = COORD_W + 1;
  localparam int PROD_W    = MUL_W + SCALE_W;
  localparam int DIV_CNT_W = $clog2(SCALE_W + 1);
  localparam longint FRAC_ONE  = 64'd1 << FRAC_BITS;
  localparam longint FRAC_HALF = 64'd1 << (FRAC_BITS - 1);

  // frame store banks split by row and column parity
  localparam int BANK_ADDR_W = (ROW_W - 1) + (COL_W - 1);
  localparam int BANK_DEPTH  = 1 << BANK_ADDR_W;

  // bilinear datapath widths
  localparam int FR_W    = FRAC_BITS + 1;
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int DIFF2_W = SAMPLE_W + 2;
  localparam int INNER_W = FR_W + DIFF2_W + 1;
  localparam int ACC_W   = SAMPLE_W + 2 * FRAC_BITS + 8;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IN_HEIGHT     = 3'd0,
    REG_IN_WIDTH      = 3'd1,
    REG_OUT_HEIGHT    = 3'd2,
    REG_OUT_WIDTH     = 3'd3,
    REG_INTERP_MODE   = 3'd4,
    REG_CORNER_ALIGN  = 3'd5,
    REG_HALF_PIXEL    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]     i0;
    logic [IDX_W-1:0]     i1;
    logic [FRAC_BITS-1:0] frac;
  } coord_t;

  typedef struct packed {
    logic                wr;
    logic                rd;
    logic [ROW_W-1:0]    wrow;
    logic [COL_W-1:0]    wcol;
    logic [SAMPLE_W-1:0] data;
    logic [ROW_W-1:0]    y0;
    logic [ROW_W-1:0]    y1;
    logic [COL_W-1:0]    x0;
    logic [COL_W-1:0]    x1;
  } store_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] p00;
    logic signed [SAMPLE_W-1:0] p01;
    logic signed [SAMPLE_W-1:0] p10;
    logic signed [SAMPLE_W-1:0] p11;
  } pix_quad_t;

endpackage

[rtl/core/ire_div.sv]
// restoring divider for the per-axis scale, one quotient bit per cycle
module ire_div
  import ire_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SCALE_W-1:0]    num,
  input  logic [OUT_SIZE_W-1:0] den,
  output logic                  busy,
  output logic [SCALE_W-1:0]    quo
);

  logic [OUT_SIZE_W-1:0] rem;
  logic [OUT_SIZE_W-1:0] den_r;
  logic [OUT_SIZE_W:0]   trial;
  logic                  ge;
  logic [SCALE_W-1:0]    sh;
  logic [DIV_CNT_W-1:0]  cnt;

  assign trial = {rem, sh[SCALE_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign quo   = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= DIV_CNT_W'(SCALE_W);
      sh    <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? OUT_SIZE_W'(trial - {1'b0, den_r}) : OUT_SIZE_W'(trial);
      sh  <= {sh[SCALE_W-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/ire_coord.sv]
// two-stage source coordinate unit for one axis
module ire_coord
  import ire_pkg::*;
(
  input  logic               clk,
  input  logic               adv,
  input  logic [COORD_W-1:0] q,
  input  logic [SCALE_W-1:0] scale,
  input  logic [CNT_W-1:0]   n,
  input  logic               bilin,
  input  logic               hpc,
  output coord_t             c
);

  localparam int IW  = PROD_W + 1 - FRAC_BITS;
  localparam int PW1 = PROD_W + 1;

  logic [MUL_W-1:0]     m;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W:0]      rnd;
  logic [PROD_W-1:0]    shifted;
  logic [PROD_W-1:0]    pos;
  logic [IW-1:0]        near_idx;
  logic [IW-1:0]        lin_idx;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        nm1;
  logic [FRAC_BITS-1:0] frac;
  logic [IDX_W-1:0]     i0;
  coord_t               c_next;

  // half-pixel centers sample at 2q+1 in half units
  assign m = hpc ? {q, 1'b1} : {1'b0, q};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= PROD_W'(m) * PROD_W'(scale);
    end
  end

  always_comb begin
    rnd      = {1'b0, prod} + PW1'(FRAC_HALF);
    near_idx = hpc ? IW'(prod >> (FRAC_BITS + 1)) : IW'(rnd >> FRAC_BITS);
    shifted  = (prod > PROD_W'(FRAC_ONE)) ? prod - PROD_W'(FRAC_ONE) : '0;
    pos      = hpc ? (shifted >> 1) : prod;
    lin_idx  = IW'(pos >> FRAC_BITS);
    nm1      = IW'(n - 1'b1);
    idx      = bilin ? lin_idx : near_idx;
    frac     = bilin ? pos[FRAC_BITS-1:0] : '0;
    if (idx > nm1) begin
      idx  = nm1;
      frac = '0;
    end
    i0          = IDX_W'(idx);
    c_next.i0   = i0;
    c_next.i1   = (idx < nm1) ? i0 + 1'b1 : IDX_W'(nm1);
    c_next.frac = frac;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c <= c_next;
    end
  end

endmodule

[rtl/core/ire_store.sv]
// frame store in four parity banks, one read or write per bank per cycle
module ire_store
  import ire_pkg::*;
(
  input  logic       clk,
  input  logic       adv,
  input  store_req_t req,
  output pix_quad_t  q
);

  logic [3:0][SAMPLE_W-1:0] rq;
  logic                     y0p, y1p, x0p, x1p;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RP = 1'((b >> 1) & 1);
    localparam logic CP = 1'(b & 1);

    logic [SAMPLE_W-1:0]    mem [BANK_DEPTH];
    logic [ROW_W-1:0]       rsel;
    logic [COL_W-1:0]       csel;
    logic [BANK_ADDR_W-1:0] raddr;
    logic [BANK_ADDR_W-1:0] waddr;
    logic                   whit;

    // each bank holds the neighbour row and column of its own parity
    assign rsel  = (req.y0[0] == RP) ? req.y0 : req.y1;
    assign csel  = (req.x0[0] == CP) ? req.x0 : req.x1;
    assign raddr = {rsel[ROW_W-1:1], csel[COL_W-1:1]};
    assign waddr = {req.wrow[ROW_W-1:1], req.wcol[COL_W-1:1]};
    assign whit  = req.wr && (req.wrow[0] == RP) && (req.wcol[0] == CP);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (whit) begin
          mem[waddr] <= req.data;
        end
        if (req.rd) begin
          rq[b] <= mem[raddr];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y0p <= req.y0[0];
      y1p <= req.y1[0];
      x0p <= req.x0[0];
      x1p <= req.x1[0];
    end
  end

  assign q.p00 = rq[{y0p, x0p}];
  assign q.p01 = rq[{y0p, x1p}];
  assign q.p10 = rq[{y1p, x0p}];
  assign q.p11 = rq[{y1p, x1p}];

endmodule

[rtl/core/image_resize_nearest_bilinear_core.sv]
// top level of the nearest / bilinear image resize core
//
//   channel   direction  handshake            payload
//   item      in         item_valid/stall     operation, row, col, sample
//   result    out        result_valid/stall   pixel_value
//   cfg       in         cfg_valid/ready      cfg_index, cfg_data
//
// one item per cycle while item_stall is low; a query's pixel shows after it passes
// the coordinate multiply, the banked store read, the blend stages and the output register
// the scale dividers start the cycle after reset or a cfg transaction and produce
// one quotient bit a cycle; item_stall stays high until both have finished
// a stalled result freezes the whole pipeline; loads leave no result
// rst is synchronous and active high; the frame store is not cleared
module image_resize_nearest_bilinear_core
  import ire_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic                       operation,
  input  logic [COORD_W-1:0]         row,
  input  logic [COORD_W-1:0]         col,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [SAMPLE_W-1:0] pixel_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic [IN_SIZE_W-1:0]  in_height, in_width;
  logic [OUT_SIZE_W-1:0] out_height, out_width;
  logic                  interp_mode, corner_align, half_pixel_centers;

  // scale dividers
  logic                  start_pend;
  logic                  div_h_busy, div_w_busy;
  logic [SCALE_W-1:0]    scale_h, scale_w;
  logic [CNT_W-1:0]      h_cnt, w_cnt;
  logic [OUT_SIZE_W-1:0] oh_eff, ow_eff;
  logic                  use_align_h, use_align_w;
  logic [SCALE_W-1:0]    num_h, num_w;
  logic [OUT_SIZE_W-1:0] den_h, den_w;

  // pipeline control
  logic adv, accept;
  logic v1, v2, v3, v4, v5, v6;
  op_t  op1, op2;
  logic [COORD_W-1:0]  row1, col1, row2, col2;
  logic [SAMPLE_W-1:0] smp1, smp2;

  coord_t     cy, cx;
  store_req_t req;
  pix_quad_t  pq;

  // blend datapath
  logic [FRAC_BITS-1:0]        fy3, fx3, fx4;
  logic signed [FR_W-1:0]      fy_s, fx_s5;
  logic signed [DIFF_W-1:0]    dy, dx;
  logic signed [DIFF2_W-1:0]   dxy;
  logic signed [FR_W+DIFF_W-1:0]  yb4;
  logic signed [FR_W+DIFF2_W-1:0] yd4;
  logic signed [DIFF_W-1:0]    c4;
  logic signed [SAMPLE_W-1:0]  p00_4, p00_5, p00_6;
  logic signed [INNER_W-1:0]   inner5;
  logic signed [ACC_W-1:0]     base5, base6, px6, acc;
  logic signed [ACC_W-1:0]     quot;
  logic                        round_up;
  logic signed [SAMPLE_W-1:0]  blend;

  // the cfg port never waits
  assign cfg_ready = 1'b1;

  // cfg transaction: write the addressed register, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      in_height          <= IN_SIZE_W'(1);
      in_width           <= IN_SIZE_W'(1);
      out_height         <= OUT_SIZE_W'(1);
      out_width          <= OUT_SIZE_W'(1);
      interp_mode        <= 1'b0;
      corner_align       <= 1'b0;
      half_pixel_centers <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_IN_HEIGHT:     in_height          <= cfg_data[IN_SIZE_W-1:0];
        REG_IN_WIDTH:      in_width           <= cfg_data[IN_SIZE_W-1:0];
        REG_OUT_HEIGHT:    out_height         <= cfg_data[OUT_SIZE_W-1:0];
        REG_OUT_WIDTH:     out_width          <= cfg_data[OUT_SIZE_W-1:0];
        REG_INTERP_MODE:   interp_mode        <= cfg_data[0];
        REG_CORNER_ALIGN:  corner_align       <= cfg_data[0];
        REG_HALF_PIXEL:    half_pixel_centers <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp input sizes to the store, treat any size of zero as one
  always_comb begin
    if (in_height == '0) begin
      h_cnt = CNT_W'(1);
    end else if (in_height > IN_SIZE_W'(MAX_IN_HEIGHT)) begin
      h_cnt = CNT_W'(MAX_IN_HEIGHT);
    end else begin
      h_cnt = CNT_W'(in_height);
    end
    if (in_width == '0) begin
      w_cnt = CNT_W'(1);
    end else if (in_width > IN_SIZE_W'(MAX_IN_WIDTH)) begin
      w_cnt = CNT_W'(MAX_IN_WIDTH);
    end else begin
      w_cnt = CNT_W'(in_width);
    end
    oh_eff      = (out_height == '0) ? OUT_SIZE_W'(1) : out_height;
    ow_eff      = (out_width == '0) ? OUT_SIZE_W'(1) : out_width;
    use_align_h = corner_align && (oh_eff > OUT_SIZE_W'(1));
    use_align_w = corner_align && (ow_eff > OUT_SIZE_W'(1));
    // corner alignment maps (in-1) onto (out-1)
    num_h = use_align_h ? SCALE_W'(h_cnt - 1'b1) << FRAC_BITS : SCALE_W'(h_cnt) << FRAC_BITS;
    num_w = use_align_w ? SCALE_W'(w_cnt - 1'b1) << FRAC_BITS : SCALE_W'(w_cnt) << FRAC_BITS;
    den_h = use_align_h ? oh_eff - 1'b1 : oh_eff;
    den_w = use_align_w ? ow_eff - 1'b1 : ow_eff;
  end

  // restart both dividers the cycle after reset or a cfg transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pend <= 1'b1;
    end else begin
      start_pend <= cfg_valid;
    end
  end

  ire_div u_div_h (
    .clk   (clk),
    .rst   (rst),
    .start (start_pend),
    .num   (num_h),
    .den   (den_h),
    .busy  (div_h_busy),
    .quo   (scale_h)
  );

  ire_div u_div_w (
    .clk   (clk),
    .rst   (rst),
    .start (start_pend),
    .num   (num_w),
    .den   (den_w),
    .busy  (div_w_busy),
    .quo   (scale_w)
  );

  // the pipeline moves unless a finished result is held
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv || start_pend || div_h_busy || div_w_busy || cfg_valid;
  assign accept     = item_valid && !item_stall;

  // stage 1: item registered while the coordinate units multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1  <= op_t'(operation);
      row1 <= row;
      col1 <= col;
      smp1 <= sample;
      op2  <= op1;
      row2 <= row1;
      col2 <= col1;
      smp2 <= smp1;
    end
  end

  ire_coord u_coord_y (
    .clk   (clk),
    .adv   (adv),
    .q     (row),
    .scale (scale_h),
    .n     (h_cnt),
    .bilin (interp_mode),
    .hpc   (half_pixel_centers),
    .c     (cy)
  );

  ire_coord u_coord_x (
    .clk   (clk),
    .adv   (adv),
    .q     (col),
    .scale (scale_w),
    .n     (w_cnt),
    .bilin (interp_mode),
    .hpc   (half_pixel_centers),
    .c     (cx)
  );

  // stage 2: loads write and queries read the banks in item order,
  // so a query always sees every earlier load without forwarding
  always_comb begin
    req.wr   = v2 && (op2 == OP_LOAD) && (row2 < COORD_W'(MAX_IN_HEIGHT))
               && (col2 < COORD_W'(MAX_IN_WIDTH));
    req.rd   = v2 && (op2 == OP_QUERY);
    req.wrow = ROW_W'(row2);
    req.wcol = COL_W'(col2);
    req.data = smp2;
    req.y0   = ROW_W'(cy.i0);
    req.y1   = ROW_W'(cy.i1);
    req.x0   = COL_W'(cx.i0);
    req.x1   = COL_W'(cx.i1);
  end

  ire_store u_store (
    .clk (clk),
    .adv (adv),
    .req (req),
    .q   (pq)
  );

  // stage 3 to 6: exact bilinear blend with 2*FRAC_BITS fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v3 <= v2 && (op2 == OP_QUERY);
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // neighbour differences: p10-p00, p01-p00 and the cross term
  always_comb begin
    fy_s = FR_W'(signed'({1'b0, fy3}));
    dy   = DIFF_W'(pq.p10) - DIFF_W'(pq.p00);
    dx   = DIFF_W'(pq.p01) - DIFF_W'(pq.p00);
    dxy  = DIFF2_W'(pq.p11) - DIFF2_W'(pq.p01) - DIFF2_W'(pq.p10) + DIFF2_W'(pq.p00);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fy3    <= cy.frac;
      fx3    <= cx.frac;
      // weights in y
      yb4    <= fy_s * dy;
      yd4    <= fy_s * dxy;
      c4     <= dx;
      p00_4  <= pq.p00;
      fx4    <= fx3;
      // inner term weighted later by fx, base holds p00 and the y term
      inner5 <= (INNER_W'(c4) <<< FRAC_BITS) + INNER_W'(yd4);
      base5  <= (ACC_W'(p00_4) <<< (2 * FRAC_BITS)) + (ACC_W'(yb4) <<< FRAC_BITS);
      fx_s5  <= FR_W'(signed'({1'b0, fx4}));
      p00_5  <= p00_4;
      px6    <= fx_s5 * inner5;
      base6  <= base5;
      p00_6  <= p00_5;
    end
  end

  // truncate toward zero
  always_comb begin
    acc      = base6 + px6;
    quot     = acc >>> (2 * FRAC_BITS);
    round_up = acc[ACC_W-1] && (acc[2*FRAC_BITS-1:0] != '0);
    blend    = SAMPLE_W'(quot + ACC_W'(round_up));
  end

  // output register parts the pipeline from the result channel
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_value <= interp_mode ? blend : p00_6;
    end
  end

endmodule

[rtl/core/ire_check.sv]
// port checker for the image resize core and its bind
module ire_check (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [7:0]  pixel_value,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // scale must be recomputed after reset before any item enters
  a_stall_after_reset: assert property (@(posedge clk) rst |=> item_stall)
    else $error("item taken right after reset");

  // no item may enter in the cycle of a cfg transaction
  a_cfg_blocks_items: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> item_stall)
    else $error("item accepted during cfg transaction");

  // a held result keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(pixel_value)))
    else $error("held result dropped or changed");

  // nothing comes out right after reset
  a_no_result_after_reset: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result right after reset");

endmodule

bind image_resize_nearest_bilinear_core ire_check u_ire_check (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .pixel_value  (pixel_value),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
